>>> rtl/dll_pkg.sv
`default_nettype none
package dll_pkg;

  // Pool size and derived widths. The null index equals NODES.
  localparam int unsigned NODES  = 16;
  localparam int unsigned IDX_W  = $clog2(NODES + 1);
  localparam int unsigned CNT_W  = $clog2(NODES + 1);
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 4;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] data_t;

  localparam idx_t NIL = idx_t'(NODES);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR      = 4'd0,
    OP_INS_FIRST  = 4'd1,
    OP_INS_LAST   = 4'd2,
    OP_GO_FIRST   = 4'd3,
    OP_GO_LAST    = 4'd4,
    OP_DEL_FIRST  = 4'd5,
    OP_DEL_LAST   = 4'd6,
    OP_DEL_AFTER  = 4'd7,
    OP_DEL_BEFORE = 4'd8,
    OP_INS_AFTER  = 4'd9,
    OP_INS_BEFORE = 4'd10,
    OP_OVERWRITE  = 4'd11,
    OP_NEXT       = 4'd12,
    OP_PREV       = 4'd13,
    OP_QUERY      = 4'd14
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LINK,
    ST_EXEC,
    ST_RES
  } state_e;

  // Write commands broadcast to every cell.
  typedef struct packed {
    logic  f0_en;
    idx_t  f0_idx;
    idx_t  f0_val;
    logic  f1_en;
    idx_t  f1_idx;
    idx_t  f1_val;
    logic  b0_en;
    idx_t  b0_idx;
    idx_t  b0_val;
    logic  b1_en;
    idx_t  b1_idx;
    idx_t  b1_val;
    logic  d_en;
    idx_t  d_idx;
    data_t d_val;
  } wr_t;

  // Read addresses broadcast to every cell.
  typedef struct packed {
    idx_t a_idx;
    idx_t b_idx;
    idx_t h_idx;
    idx_t t_idx;
    idx_t c_idx;
  } rd_req_t;

  // Read bus that ripples along the row of cells.
  typedef struct packed {
    idx_t  a_fwd;
    idx_t  a_bwd;
    idx_t  b_fwd;
    idx_t  b_bwd;
    data_t h_data;
    data_t t_data;
    data_t c_data;
  } rd_bus_t;

endpackage
`default_nettype wire

>>> rtl/dll_in_if.sv
`default_nettype none
interface dll_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [dll_pkg::OP_W-1:0]             operation;
  logic signed [dll_pkg::DATA_W-1:0]    value;

  modport source (output valid, output operation, output value, input ready);
  modport sink (input valid, input operation, input value, output ready);
endinterface
`default_nettype wire

>>> rtl/dll_out_if.sv
`default_nettype none
interface dll_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [dll_pkg::DATA_W-1:0] first_value;
  logic signed [dll_pkg::DATA_W-1:0] last_value;
  logic signed [dll_pkg::DATA_W-1:0] active_value;
  logic                              list_empty;
  logic                              has_active;
  logic [dll_pkg::CNT_W-1:0]         element_count;
  logic                              status;

  modport source (output valid, output first_value, output last_value, output active_value,
                  output list_empty, output has_active, output element_count,
                  output status, input ready);
  modport sink (input valid, input first_value, input last_value, input active_value,
                input list_empty, input has_active, input element_count,
                input status, output ready);
endinterface
`default_nettype wire

>>> rtl/dll_cell.sv
`default_nettype none
module dll_cell (
  input  wire logic             clk_i,
  input  wire dll_pkg::idx_t    cell_id_i,
  input  wire dll_pkg::wr_t     wr_i,
  input  wire dll_pkg::rd_req_t rd_req_i,
  input  wire dll_pkg::rd_bus_t rd_bus_i,
  output dll_pkg::rd_bus_t      rd_bus_o
);

  dll_pkg::data_t data_q;
  dll_pkg::idx_t  fwd_q;
  dll_pkg::idx_t  bwd_q;

  // Node storage; the second port of each link wins on a clash.
  always_ff @(posedge clk_i) begin
    if (wr_i.f0_en && wr_i.f0_idx == cell_id_i) fwd_q <= wr_i.f0_val;
    if (wr_i.f1_en && wr_i.f1_idx == cell_id_i) fwd_q <= wr_i.f1_val;
    if (wr_i.b0_en && wr_i.b0_idx == cell_id_i) bwd_q <= wr_i.b0_val;
    if (wr_i.b1_en && wr_i.b1_idx == cell_id_i) bwd_q <= wr_i.b1_val;
    if (wr_i.d_en && wr_i.d_idx == cell_id_i) data_q <= wr_i.d_val;
  end

  // Add this node's fields to the read bus coming from the previous cell.
  always_comb begin
    rd_bus_o = rd_bus_i;
    if (rd_req_i.a_idx == cell_id_i) begin
      rd_bus_o.a_fwd = rd_bus_i.a_fwd | fwd_q;
      rd_bus_o.a_bwd = rd_bus_i.a_bwd | bwd_q;
    end
    if (rd_req_i.b_idx == cell_id_i) begin
      rd_bus_o.b_fwd = rd_bus_i.b_fwd | fwd_q;
      rd_bus_o.b_bwd = rd_bus_i.b_bwd | bwd_q;
    end
    if (rd_req_i.h_idx == cell_id_i) rd_bus_o.h_data = rd_bus_i.h_data | data_q;
    if (rd_req_i.t_idx == cell_id_i) rd_bus_o.t_data = rd_bus_i.t_data | data_q;
    if (rd_req_i.c_idx == cell_id_i) rd_bus_o.c_data = rd_bus_i.c_data | data_q;
  end

endmodule
`default_nettype wire

>>> rtl/dll_chain.sv
`default_nettype none
module dll_chain (
  input  wire logic             clk_i,
  input  wire dll_pkg::wr_t     wr_i,
  input  wire dll_pkg::rd_req_t rd_req_i,
  output dll_pkg::rd_bus_t      rd_bus_o
);

  dll_pkg::rd_bus_t bus [dll_pkg::NODES+1];

  // The read bus starts empty and each cell adds its matching fields.
  assign bus[0] = '0;

  for (genvar g = 0; g < dll_pkg::NODES; g++) begin : g_cell
    dll_cell u_cell (
      .clk_i     (clk_i),
      .cell_id_i (dll_pkg::idx_t'(g)),
      .wr_i      (wr_i),
      .rd_req_i  (rd_req_i),
      .rd_bus_i  (bus[g]),
      .rd_bus_o  (bus[g+1])
    );
  end

  assign rd_bus_o = bus[dll_pkg::NODES];

endmodule
`default_nettype wire

>>> rtl/doubly_linked_list_with_cursor.sv
// Doubly linked list of signed 32-bit values with a cursor.
// Input channel in_i carries one operation and a value per item; output
// channel out_o returns one result item per input item: first, last and
// cursor values, empty and active flags, element count and status.
// Each item runs through three steps: a first link read, a second link
// read with the list update, and a data read into the output register.
// The second link read depends on the first (neighbor of a neighbor), so
// the two link reads are separate steps. A new item is accepted in the cycle
// its predecessor's result is loaded, so only one item is in flight at a time.
// Nodes live in a row of cells, one per node, each holding value and links;
// reads ripple along the row and writes are broadcast to all cells.
// Reset (rst_ni low) empties the list and the node pool; node contents are
// left as they are and are rewritten when a node is allocated.
// If the receiver stalls, one result waits in the output register and the
// block holds the next item after its update step until that result leaves.
`default_nettype none
module doubly_linked_list_with_cursor (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dll_in_if.sink    in_i,
  dll_out_if.source out_o
);

  dll_pkg::state_e  state_q, state_d;
  dll_pkg::op_e     op_q;
  dll_pkg::data_t   val_q;
  dll_pkg::idx_t    head_q, head_d;
  dll_pkg::idx_t    tail_q, tail_d;
  dll_pkg::idx_t    cur_q, cur_d;
  dll_pkg::idx_t    free_q, free_d;
  dll_pkg::idx_t    bump_q, bump_d;
  dll_pkg::cnt_t    count_q, count_d;
  dll_pkg::idx_t    l1f_q, l1b_q, fn_q;
  logic             status_q, status_d;
  logic             out_valid_q;
  logic             can_load;
  logic             accept;
  logic             load;
  dll_pkg::wr_t     wr;
  dll_pkg::rd_req_t rd_req;
  dll_pkg::rd_bus_t rd_bus;

  dll_chain u_chain (
    .clk_i    (clk_i),
    .wr_i     (wr),
    .rd_req_i (rd_req),
    .rd_bus_o (rd_bus)
  );

  assign can_load = !out_valid_q || out_o.ready;
  assign accept   = in_i.valid && in_i.ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dll_pkg::ST_IDLE: if (in_i.valid) state_d = dll_pkg::ST_LINK;
      dll_pkg::ST_LINK: state_d = dll_pkg::ST_EXEC;
      dll_pkg::ST_EXEC: state_d = dll_pkg::ST_RES;
      dll_pkg::ST_RES: begin
        if (can_load) state_d = in_i.valid ? dll_pkg::ST_LINK : dll_pkg::ST_IDLE;
      end
      default: state_d = dll_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_i.ready = 1'b0;
    load       = 1'b0;
    unique case (state_q)
      dll_pkg::ST_IDLE: in_i.ready = 1'b1;
      dll_pkg::ST_RES: begin
        in_i.ready = can_load;
        load       = can_load;
      end
      default: ;
    endcase
  end

  // Read addresses: the first link read follows head, tail or cursor; the
  // second port reads the free list in the first step and the neighbor's
  // neighbor in the update step.
  always_comb begin
    rd_req.h_idx = head_q;
    rd_req.t_idx = tail_q;
    rd_req.c_idx = cur_q;
    unique case (op_q)
      dll_pkg::OP_DEL_FIRST: rd_req.a_idx = head_q;
      dll_pkg::OP_DEL_LAST:  rd_req.a_idx = tail_q;
      default:               rd_req.a_idx = cur_q;
    endcase
    if (state_q == dll_pkg::ST_LINK) begin
      rd_req.b_idx = free_q;
    end else begin
      rd_req.b_idx = (op_q == dll_pkg::OP_DEL_BEFORE) ? l1b_q : l1f_q;
    end
  end

  // List update in the execute step.
  always_comb begin
    logic          is_ins;
    logic          full;
    logic          rel;
    dll_pkg::idx_t n;
    dll_pkg::idx_t m;
    dll_pkg::op_e  eff_op;

    head_d   = head_q;
    tail_d   = tail_q;
    cur_d    = cur_q;
    free_d   = free_q;
    bump_d   = bump_q;
    count_d  = count_q;
    status_d = status_q;
    wr       = '0;
    is_ins   = 1'b0;
    full     = 1'b0;
    rel      = 1'b0;
    n        = dll_pkg::NIL;
    m        = dll_pkg::NIL;
    eff_op   = op_q;

    if (state_q == dll_pkg::ST_EXEC) begin
      is_ins = (op_q == dll_pkg::OP_INS_FIRST) || (op_q == dll_pkg::OP_INS_LAST) ||
               (((op_q == dll_pkg::OP_INS_AFTER) || (op_q == dll_pkg::OP_INS_BEFORE)) &&
                (cur_q != dll_pkg::NIL));
      // Allocate from the free list first, then from never-used nodes.
      if (is_ins) begin
        if (free_q != dll_pkg::NIL) begin
          n      = free_q;
          free_d = fn_q;
        end else if (bump_q != dll_pkg::NIL) begin
          n      = bump_q;
          bump_d = bump_q + dll_pkg::idx_t'(1);
        end else begin
          full = 1'b1;
        end
      end
      status_d = full;
      if (full) eff_op = dll_pkg::OP_QUERY;
      if (is_ins && !full) begin
        wr.d_en  = 1'b1;
        wr.d_idx = n;
        wr.d_val = val_q;
        count_d  = count_q + dll_pkg::cnt_t'(1);
      end

      unique case (eff_op)
        dll_pkg::OP_CLEAR: begin
          head_d  = dll_pkg::NIL;
          tail_d  = dll_pkg::NIL;
          cur_d   = dll_pkg::NIL;
          free_d  = dll_pkg::NIL;
          bump_d  = '0;
          count_d = '0;
        end
        dll_pkg::OP_INS_FIRST: begin
          wr.b0_en = 1'b1; wr.b0_idx = n; wr.b0_val = dll_pkg::NIL;
          wr.f0_en = 1'b1; wr.f0_idx = n; wr.f0_val = head_q;
          if (head_q != dll_pkg::NIL) begin
            wr.b1_en = 1'b1; wr.b1_idx = head_q; wr.b1_val = n;
          end else begin
            tail_d = n;
          end
          head_d = n;
        end
        dll_pkg::OP_INS_LAST: begin
          wr.f0_en = 1'b1; wr.f0_idx = n; wr.f0_val = dll_pkg::NIL;
          wr.b0_en = 1'b1; wr.b0_idx = n; wr.b0_val = tail_q;
          if (tail_q != dll_pkg::NIL) begin
            wr.f1_en = 1'b1; wr.f1_idx = tail_q; wr.f1_val = n;
          end else begin
            head_d = n;
          end
          tail_d = n;
        end
        dll_pkg::OP_GO_FIRST: cur_d = head_q;
        dll_pkg::OP_GO_LAST:  cur_d = tail_q;
        dll_pkg::OP_DEL_FIRST: begin
          if (head_q != dll_pkg::NIL) begin
            rel = 1'b1;
            m   = head_q;
            if (cur_q == head_q) cur_d = dll_pkg::NIL;
            head_d = l1f_q;
            if (l1f_q != dll_pkg::NIL) begin
              wr.b0_en = 1'b1; wr.b0_idx = l1f_q; wr.b0_val = dll_pkg::NIL;
            end else begin
              tail_d = dll_pkg::NIL;
            end
          end
        end
        dll_pkg::OP_DEL_LAST: begin
          if (tail_q != dll_pkg::NIL) begin
            rel = 1'b1;
            m   = tail_q;
            if (cur_q == tail_q) cur_d = dll_pkg::NIL;
            tail_d = l1b_q;
            if (l1b_q != dll_pkg::NIL) begin
              wr.f0_en = 1'b1; wr.f0_idx = l1b_q; wr.f0_val = dll_pkg::NIL;
            end else begin
              head_d = dll_pkg::NIL;
            end
          end
        end
        dll_pkg::OP_DEL_AFTER: begin
          if (cur_q != dll_pkg::NIL && cur_q != tail_q) begin
            rel = 1'b1;
            m   = l1f_q;
            wr.f0_en = 1'b1; wr.f0_idx = cur_q; wr.f0_val = rd_bus.b_fwd;
            if (rd_bus.b_fwd != dll_pkg::NIL) begin
              wr.b0_en = 1'b1; wr.b0_idx = rd_bus.b_fwd; wr.b0_val = cur_q;
            end else begin
              tail_d = cur_q;
            end
          end
        end
        dll_pkg::OP_DEL_BEFORE: begin
          if (cur_q != dll_pkg::NIL && cur_q != head_q) begin
            rel = 1'b1;
            m   = l1b_q;
            wr.b0_en = 1'b1; wr.b0_idx = cur_q; wr.b0_val = rd_bus.b_bwd;
            if (rd_bus.b_bwd != dll_pkg::NIL) begin
              wr.f0_en = 1'b1; wr.f0_idx = rd_bus.b_bwd; wr.f0_val = cur_q;
            end else begin
              head_d = cur_q;
            end
          end
        end
        dll_pkg::OP_INS_AFTER: begin
          if (cur_q != dll_pkg::NIL) begin
            wr.f0_en = 1'b1; wr.f0_idx = n; wr.f0_val = l1f_q;
            wr.b0_en = 1'b1; wr.b0_idx = n; wr.b0_val = cur_q;
            if (l1f_q != dll_pkg::NIL) begin
              wr.b1_en = 1'b1; wr.b1_idx = l1f_q; wr.b1_val = n;
            end else begin
              tail_d = n;
            end
            wr.f1_en = 1'b1; wr.f1_idx = cur_q; wr.f1_val = n;
          end
        end
        dll_pkg::OP_INS_BEFORE: begin
          if (cur_q != dll_pkg::NIL) begin
            wr.b0_en = 1'b1; wr.b0_idx = n; wr.b0_val = l1b_q;
            wr.f0_en = 1'b1; wr.f0_idx = n; wr.f0_val = cur_q;
            if (l1b_q != dll_pkg::NIL) begin
              wr.f1_en = 1'b1; wr.f1_idx = l1b_q; wr.f1_val = n;
            end else begin
              head_d = n;
            end
            wr.b1_en = 1'b1; wr.b1_idx = cur_q; wr.b1_val = n;
          end
        end
        dll_pkg::OP_OVERWRITE: begin
          if (cur_q != dll_pkg::NIL) begin
            wr.d_en = 1'b1; wr.d_idx = cur_q; wr.d_val = val_q;
          end
        end
        dll_pkg::OP_NEXT: if (cur_q != dll_pkg::NIL) cur_d = l1f_q;
        dll_pkg::OP_PREV: if (cur_q != dll_pkg::NIL) cur_d = l1b_q;
        default: ;
      endcase

      // A released node goes on top of the free list.
      if (rel) begin
        wr.f1_en = 1'b1; wr.f1_idx = m; wr.f1_val = free_q;
        free_d   = m;
        if (count_q != '0) count_d = count_q - dll_pkg::cnt_t'(1);
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dll_pkg::ST_IDLE;
      head_q      <= dll_pkg::NIL;
      tail_q      <= dll_pkg::NIL;
      cur_q       <= dll_pkg::NIL;
      free_q      <= dll_pkg::NIL;
      bump_q      <= '0;
      count_q     <= '0;
      status_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      cur_q    <= cur_d;
      free_q   <= free_d;
      bump_q   <= bump_d;
      count_q  <= count_d;
      status_q <= status_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item and first link read registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= dll_pkg::op_e'(in_i.operation);
      val_q <= in_i.value;
    end
    if (state_q == dll_pkg::ST_LINK) begin
      l1f_q <= rd_bus.a_fwd;
      l1b_q <= rd_bus.a_bwd;
      fn_q  <= rd_bus.b_fwd;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_o.first_value   <= (head_q != dll_pkg::NIL) ? signed'(rd_bus.h_data) : '0;
      out_o.last_value    <= (tail_q != dll_pkg::NIL) ? signed'(rd_bus.t_data) : '0;
      out_o.active_value  <= (cur_q != dll_pkg::NIL) ? signed'(rd_bus.c_data) : '0;
      out_o.list_empty    <= (head_q == dll_pkg::NIL);
      out_o.has_active    <= (cur_q != dll_pkg::NIL);
      out_o.element_count <= count_q;
      out_o.status        <= status_q;
    end
  end

  assign out_o.valid = out_valid_q;

endmodule
`default_nettype wire

>>> test/doubly_linked_list_with_cursor_tb.sv
`default_nettype none
module doubly_linked_list_with_cursor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned RANDOM_ITEMS   = 900;
  localparam int unsigned HOLD_CYCLES    = 200;

  typedef struct packed {
    logic [dll_pkg::OP_W-1:0] operation;
    dll_pkg::data_t           value;
  } list_cmd_t;

  typedef struct packed {
    dll_pkg::data_t first_value;
    dll_pkg::data_t last_value;
    dll_pkg::data_t active_value;
    logic           list_empty;
    logic           has_active;
    dll_pkg::cnt_t  element_count;
    logic           status;
  } list_view_t;

  logic clk_i;
  logic rst_ni;

  dll_in_if  in_ch();
  dll_out_if out_ch();

  doubly_linked_list_with_cursor u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  // Shadow copy of the list, the pool and the cursor.
  dll_pkg::data_t pool_data [dll_pkg::NODES];
  dll_pkg::idx_t  pool_next [dll_pkg::NODES];
  dll_pkg::idx_t  pool_prev [dll_pkg::NODES];
  dll_pkg::idx_t  head_q, tail_q, cursor_q, free_q, bump_q;
  int unsigned    size_q;

  list_cmd_t   pending_cmds [$];
  list_view_t  expected_views [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_req;
  bit          hold_seen;
  int unsigned hold_left;
  int unsigned mismatches = 0;
  int unsigned accepted_cmds = 0;
  int unsigned checked_views = 0;
  int unsigned full_drops = 0;
  int unsigned quiet_cycles = 0;

  // Clock generation.
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic void list_reset();
    head_q   = dll_pkg::NIL;
    tail_q   = dll_pkg::NIL;
    cursor_q = dll_pkg::NIL;
    free_q   = dll_pkg::NIL;
    bump_q   = '0;
    size_q   = 0;
    for (int i = 0; i < dll_pkg::NODES; i++) begin
      pool_data[i] = '0;
      pool_next[i] = dll_pkg::NIL;
      pool_prev[i] = dll_pkg::NIL;
    end
  endfunction

  function automatic void free_node(dll_pkg::idx_t n);
    pool_next[n] = free_q;
    free_q = n;
    if (size_q > 0) size_q--;
  endfunction

  // Applies one operation to the shadow list and returns the view after it.
  function automatic list_view_t list_apply(list_cmd_t cmd);
    list_view_t    v;
    dll_pkg::op_e  op;
    dll_pkg::idx_t n, m, k;
    logic          dropped;
    op = dll_pkg::op_e'(cmd.operation);
    n = dll_pkg::NIL;
    dropped = 1'b0;
    if (op inside {dll_pkg::OP_INS_FIRST, dll_pkg::OP_INS_LAST} ||
        (op inside {dll_pkg::OP_INS_AFTER, dll_pkg::OP_INS_BEFORE} &&
         cursor_q != dll_pkg::NIL)) begin
      if (free_q != dll_pkg::NIL) begin
        n = free_q;
        free_q = pool_next[n];
      end else if (bump_q < dll_pkg::NODES) begin
        n = bump_q;
        bump_q = bump_q + dll_pkg::idx_t'(1);
      end
      if (n == dll_pkg::NIL) begin
        dropped = 1'b1;
        op = dll_pkg::OP_QUERY;
      end else begin
        pool_data[n] = cmd.value;
        size_q++;
      end
    end
    case (op)
      dll_pkg::OP_CLEAR: list_reset();
      dll_pkg::OP_INS_FIRST: begin
        pool_prev[n] = dll_pkg::NIL;
        pool_next[n] = head_q;
        if (head_q != dll_pkg::NIL) pool_prev[head_q] = n; else tail_q = n;
        head_q = n;
      end
      dll_pkg::OP_INS_LAST: begin
        pool_next[n] = dll_pkg::NIL;
        pool_prev[n] = tail_q;
        if (tail_q != dll_pkg::NIL) pool_next[tail_q] = n; else head_q = n;
        tail_q = n;
      end
      dll_pkg::OP_GO_FIRST: cursor_q = head_q;
      dll_pkg::OP_GO_LAST: cursor_q = tail_q;
      dll_pkg::OP_DEL_FIRST: if (head_q != dll_pkg::NIL) begin
        m = head_q;
        if (cursor_q == m) cursor_q = dll_pkg::NIL;
        head_q = pool_next[m];
        if (head_q != dll_pkg::NIL) pool_prev[head_q] = dll_pkg::NIL;
        else tail_q = dll_pkg::NIL;
        free_node(m);
      end
      dll_pkg::OP_DEL_LAST: if (tail_q != dll_pkg::NIL) begin
        m = tail_q;
        if (cursor_q == m) cursor_q = dll_pkg::NIL;
        tail_q = pool_prev[m];
        if (tail_q != dll_pkg::NIL) pool_next[tail_q] = dll_pkg::NIL;
        else head_q = dll_pkg::NIL;
        free_node(m);
      end
      dll_pkg::OP_DEL_AFTER: if (cursor_q != dll_pkg::NIL && cursor_q != tail_q) begin
        m = pool_next[cursor_q];
        k = pool_next[m];
        pool_next[cursor_q] = k;
        if (k != dll_pkg::NIL) pool_prev[k] = cursor_q; else tail_q = cursor_q;
        free_node(m);
      end
      dll_pkg::OP_DEL_BEFORE: if (cursor_q != dll_pkg::NIL && cursor_q != head_q) begin
        m = pool_prev[cursor_q];
        k = pool_prev[m];
        pool_prev[cursor_q] = k;
        if (k != dll_pkg::NIL) pool_next[k] = cursor_q; else head_q = cursor_q;
        free_node(m);
      end
      dll_pkg::OP_INS_AFTER: if (cursor_q != dll_pkg::NIL) begin
        m = pool_next[cursor_q];
        pool_next[n] = m;
        pool_prev[n] = cursor_q;
        if (m != dll_pkg::NIL) pool_prev[m] = n; else tail_q = n;
        pool_next[cursor_q] = n;
      end
      dll_pkg::OP_INS_BEFORE: if (cursor_q != dll_pkg::NIL) begin
        m = pool_prev[cursor_q];
        pool_prev[n] = m;
        pool_next[n] = cursor_q;
        if (m != dll_pkg::NIL) pool_next[m] = n; else head_q = n;
        pool_prev[cursor_q] = n;
      end
      dll_pkg::OP_OVERWRITE: if (cursor_q != dll_pkg::NIL) pool_data[cursor_q] = cmd.value;
      dll_pkg::OP_NEXT: if (cursor_q != dll_pkg::NIL) cursor_q = pool_next[cursor_q];
      dll_pkg::OP_PREV: if (cursor_q != dll_pkg::NIL) cursor_q = pool_prev[cursor_q];
      default: ;
    endcase
    v.first_value   = (head_q != dll_pkg::NIL) ? pool_data[head_q] : '0;
    v.last_value    = (tail_q != dll_pkg::NIL) ? pool_data[tail_q] : '0;
    v.active_value  = (cursor_q != dll_pkg::NIL) ? pool_data[cursor_q] : '0;
    v.list_empty    = (head_q == dll_pkg::NIL);
    v.has_active    = (cursor_q != dll_pkg::NIL);
    v.element_count = dll_pkg::cnt_t'(size_q);
    v.status        = dropped;
    return v;
  endfunction

  function automatic dll_pkg::data_t rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return '0;
      default: return $urandom();
    endcase
  endfunction

  function automatic void push_cmd(dll_pkg::op_e op, dll_pkg::data_t value);
    list_cmd_t c;
    c.operation = op;
    c.value = value;
    pending_cmds.push_back(c);
  endfunction

  // Random operation, weighted toward inserts and cursor moves so the list
  // grows deep and the pool fills; clear stays rare.
  function automatic void push_random_cmd();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 1) push_cmd(dll_pkg::OP_CLEAR, rand_value());
    else if (r < 4) pending_cmds.push_back(list_cmd_t'({4'hf, rand_value()}));
    else if (r < 20)
      push_cmd(dll_pkg::op_e'($urandom_range(dll_pkg::OP_INS_FIRST, dll_pkg::OP_INS_LAST)),
               rand_value());
    else if (r < 34)
      push_cmd(dll_pkg::op_e'($urandom_range(dll_pkg::OP_INS_AFTER, dll_pkg::OP_INS_BEFORE)),
               rand_value());
    else if (r < 50)
      push_cmd(dll_pkg::op_e'($urandom_range(dll_pkg::OP_NEXT, dll_pkg::OP_PREV)),
               rand_value());
    else if (r < 58)
      push_cmd(dll_pkg::op_e'($urandom_range(dll_pkg::OP_GO_FIRST, dll_pkg::OP_GO_LAST)),
               rand_value());
    else
      push_cmd(dll_pkg::op_e'($urandom_range(dll_pkg::OP_CLEAR + 1, dll_pkg::OP_QUERY)),
               rand_value());
  endfunction

  // Driver: offers queued items, idling at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid     <= 1'b0;
      in_ch.operation <= '0;
      in_ch.value     <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        accepted_cmds++;
        expected_views.push_back(list_apply(pending_cmds.pop_front()));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_ch.valid     <= 1'b1;
          in_ch.operation <= pending_cmds[0].operation;
          in_ch.value     <= pending_cmds[0].value;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready, with random stalls and one long hold-off counted here.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
      hold_seen = 1'b0;
    end else begin
      if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Monitor: compares every result with the oldest expectation.
  always @(posedge clk_i) begin
    list_view_t got, want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.first_value   = out_ch.first_value;
      got.last_value    = out_ch.last_value;
      got.active_value  = out_ch.active_value;
      got.list_empty    = out_ch.list_empty;
      got.has_active    = out_ch.has_active;
      got.element_count = out_ch.element_count;
      got.status        = out_ch.status;
      if (expected_views.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result item: %p", got);
      end else begin
        want = expected_views.pop_front();
        checked_views++;
        if (want.status) full_drops++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch on result %0d: expected %p, got %p", checked_views, want, got);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted item or taken result.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", expected_views.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_ch.valid || expected_views.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    list_reset();
    send_idle_pct = 33;
    recv_idle_pct = 58;
    hold_req = 1'b0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty-list cases, inactive cursor, ends, overwrite, full pool.
    push_cmd(dll_pkg::OP_QUERY, '0);
    push_cmd(dll_pkg::OP_DEL_FIRST, '0);
    push_cmd(dll_pkg::OP_DEL_LAST, '0);
    push_cmd(dll_pkg::OP_GO_FIRST, '0);
    push_cmd(dll_pkg::OP_INS_AFTER, 32'h1234_5678);
    push_cmd(dll_pkg::OP_NEXT, '0);
    push_cmd(dll_pkg::OP_INS_FIRST, 32'h8000_0000);
    push_cmd(dll_pkg::OP_INS_LAST, 32'h7fff_ffff);
    push_cmd(dll_pkg::OP_GO_FIRST, '0);
    push_cmd(dll_pkg::OP_DEL_BEFORE, '0);
    push_cmd(dll_pkg::OP_INS_BEFORE, 32'hffff_ffff);
    push_cmd(dll_pkg::OP_INS_AFTER, 32'h0000_0000);
    push_cmd(dll_pkg::OP_OVERWRITE, 32'h5555_aaaa);
    push_cmd(dll_pkg::OP_GO_LAST, '0);
    push_cmd(dll_pkg::OP_DEL_AFTER, '0);
    push_cmd(dll_pkg::OP_DEL_BEFORE, '0);
    push_cmd(dll_pkg::OP_NEXT, '0);
    push_cmd(dll_pkg::OP_GO_FIRST, '0);
    push_cmd(dll_pkg::OP_PREV, '0);
    push_cmd(dll_pkg::OP_GO_FIRST, '0);
    push_cmd(dll_pkg::OP_DEL_FIRST, '0);
    pending_cmds.push_back(list_cmd_t'({4'hf, 32'haaaa_5555}));
    for (int i = 0; i < 18; i++) push_cmd(dll_pkg::OP_INS_LAST, $urandom());
    push_cmd(dll_pkg::OP_GO_LAST, '0);
    push_cmd(dll_pkg::OP_DEL_LAST, '0);
    push_cmd(dll_pkg::OP_CLEAR, '0);

    // Random phases with changing idle pattern.
    for (int phase = 0; phase < 3; phase++) begin
      for (int i = 0; i < RANDOM_ITEMS / 3; i++) push_random_cmd();
      // Long receiver hold-off while the sender keeps offering.
      if (phase == 1) hold_req = 1'b1;
      wait_drained();
      send_idle_pct = (phase == 0) ? 58 : 0;
      recv_idle_pct = (phase == 0) ? 33 : 0;
    end
    repeat (20) @(posedge clk_i);

    $display("Run covered %0d items and %0d results, %0d inserts dropped on a full pool.",
             accepted_cmds, checked_views, full_drops);
    if (mismatches == 0 && expected_views.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_views.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
